[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the largest free square finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LFSQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfsq assertion failed");

// next-cycle implication
`define LFSQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfsq assertion failed");

`endif

[design/lfsq_pkg.sv]
// ----------------------------------------------------------------------------
// lfsq_pkg
// Widths, register codes and shared types of the largest free square finder.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsq_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int SCORE_W   = 11;
    localparam int SIZE_W    = 11;
    localparam int REG_IDX_W = 1;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               free;
        logic               first;
        logic               grid_end;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } cell_ctl_t;

    typedef struct packed {
        logic [COL_W-1:0]   left_col;
        logic [ROW_W-1:0]   top_row;
        logic [SCORE_W-1:0] square_side;
    } result_t;

endpackage

`default_nettype wire

[design/lfsq_line_buf.sv]
// ----------------------------------------------------------------------------
// lfsq_line_buf
// One-row score buffer: synchronous read, one write port, write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsq_line_buf
    import lfsq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               rd_en,
    input  wire logic [COL_W-1:0]   rd_addr,
    output logic      [SCORE_W-1:0] rd_data,
    input  wire logic               wr_en,
    input  wire logic [COL_W-1:0]   wr_addr,
    input  wire logic [SCORE_W-1:0] wr_data
);

    logic [SCORE_W-1:0] mem [MAX_COLS];
    logic [SCORE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // bypass a write that lands on the entry being read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/lfsq_score_unit.sv]
// ----------------------------------------------------------------------------
// lfsq_score_unit
// Scores one cell, tracks the best square and flags the result at grid end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfsq_score_unit
    import lfsq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_ctl_t          ctl,
    input  wire logic [SCORE_W-1:0] top_score,
    output logic                    wr_en,
    output logic      [COL_W-1:0]   wr_addr,
    output logic      [SCORE_W-1:0] wr_data,
    output logic                    res_push,
    output result_t                 res
);

    logic [SCORE_W-1:0] left_reg,  left_next;
    logic [SCORE_W-1:0] diag_reg,  diag_next;
    logic [SCORE_W-1:0] bside_reg, bside_next;
    logic [ROW_W-1:0]   brow_reg,  brow_next;
    logic [COL_W-1:0]   bcol_reg,  bcol_next;

    logic [SCORE_W-1:0] min_ld;
    logic [SCORE_W-1:0] min_all;
    logic [SCORE_W-1:0] score;
    logic [SIZE_W-1:0]  row_p1;
    logic [SIZE_W-1:0]  col_p1;
    logic [SIZE_W-1:0]  row_diff;
    logic [SIZE_W-1:0]  col_diff;
    logic               better;
    logic [SCORE_W-1:0] upd_side;
    logic [ROW_W-1:0]   upd_row;
    logic [COL_W-1:0]   upd_col;

    always_comb begin
        min_ld  = (left_reg < diag_reg) ? left_reg : diag_reg;
        min_all = (min_ld < top_score) ? min_ld : top_score;
        if (!ctl.free) begin
            score = '0;
        end else if (ctl.first) begin
            score = SCORE_W'(1);
        end else begin
            score = min_all + SCORE_W'(1);
        end

        row_p1   = {1'b0, ctl.row} + SIZE_W'(1);
        col_p1   = {1'b0, ctl.col} + SIZE_W'(1);
        row_diff = row_p1 - score;
        col_diff = col_p1 - score;
        better   = score > bside_reg;

        if (better) begin
            upd_side = score;
            upd_row  = (score > row_p1) ? '0 : row_diff[ROW_W-1:0];
            upd_col  = (score > col_p1) ? '0 : col_diff[COL_W-1:0];
        end else begin
            upd_side = bside_reg;
            upd_row  = brow_reg;
            upd_col  = bcol_reg;
        end

        left_next  = left_reg;
        diag_next  = diag_reg;
        bside_next = bside_reg;
        brow_next  = brow_reg;
        bcol_next  = bcol_reg;
        if (ctl.valid) begin
            if (ctl.grid_end) begin
                left_next  = '0;
                diag_next  = '0;
                bside_next = '0;
                brow_next  = '0;
                bcol_next  = '0;
            end else begin
                left_next  = score;
                diag_next  = top_score;
                bside_next = upd_side;
                brow_next  = upd_row;
                bcol_next  = upd_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            diag_reg  <= '0;
            bside_reg <= '0;
            brow_reg  <= '0;
            bcol_reg  <= '0;
        end else begin
            left_reg  <= left_next;
            diag_reg  <= diag_next;
            bside_reg <= bside_next;
            brow_reg  <= brow_next;
            bcol_reg  <= bcol_next;
        end
    end

    assign wr_en            = ctl.valid;
    assign wr_addr          = ctl.col;
    assign wr_data          = score;
    assign res_push         = ctl.valid && ctl.grid_end;
    assign res.square_side  = upd_side;
    assign res.top_row      = upd_row;
    assign res.left_col     = upd_col;

    `LFSQ_ASSERT_NOW(a_first_score_le_one, aclk, aresetn, ctl.valid && ctl.first, score <= SCORE_W'(1))
    `LFSQ_ASSERT_NEXT(a_best_cleared_after_end, aclk, aresetn, res_push, bside_reg == '0)

endmodule

`default_nettype wire

[design/lfsq_result_fifo.sv]
// ----------------------------------------------------------------------------
// lfsq_result_fifo
// Small result queue that decouples the scoring path from the output request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfsq_result_fifo
    import lfsq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire result_t              push_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_data,
    output logic      [RES_CNT_W-1:0] level
);

    result_t              entries [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                 pop;

    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? wr_ptr_reg + RES_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + RES_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + RES_CNT_W'(push) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = cnt_reg != '0;
    assign out_data  = entries[rd_ptr_reg];
    assign level     = cnt_reg;

    `LFSQ_ASSERT_NOW(a_no_overflow, aclk, aresetn, push && !pop, cnt_reg < RES_CNT_W'(RES_DEPTH))
    `LFSQ_ASSERT_NOW(a_level_bound, aclk, aresetn, 1'b1, cnt_reg <= RES_CNT_W'(RES_DEPTH))

endmodule

`default_nettype wire

[design/largest_free_square_finder.sv]
// ----------------------------------------------------------------------------
// largest_free_square_finder
// Largest all-free square search over a row-major grid stream.
// ----------------------------------------------------------------------------
// Takes one grid cell per clock on the s_ side and, after the last cell of a
// num_rows by num_cols grid, delivers the side and top-left corner of the first
// largest free square on the m_ side, by way of the registered cell control
// and the result queue. The line buffer, a 1024 x 11 synchronous RAM, is read
// when a cell is taken and written with its score in the next cycle, with a
// bypass for the same column. Input stalls only while the four-entry result
// queue could overflow. The line buffer is not cleared after reset; every
// entry is written in the first row before its value is used.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module largest_free_square_finder
    import lfsq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_addr,
    input  wire logic [SIZE_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [0] cell_free
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata    // [10:0] square_side, [20:11] top_row,
                                                  // [30:21] left_col
);

    logic [SIZE_W-1:0]    num_rows_reg;
    logic [SIZE_W-1:0]    num_cols_reg;
    logic [SIZE_W-1:0]    rows_eff;
    logic [SIZE_W-1:0]    cols_eff;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    cell_ctl_t            ctl_reg, ctl_next;
    logic                 s_accept;
    logic                 last_col;
    logic                 last_row;
    logic [SCORE_W-1:0]   top_score;
    logic                 wr_en;
    logic [COL_W-1:0]     wr_addr;
    logic [SCORE_W-1:0]   wr_data;
    logic                 res_push;
    result_t              res;
    result_t              out_res;
    logic [RES_CNT_W-1:0] level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= SIZE_W'(1);
            num_cols_reg <= SIZE_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                REG_NUM_COLS: num_cols_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        if (num_rows_reg == '0) begin
            rows_eff = SIZE_W'(1);
        end else if (num_rows_reg > SIZE_W'(MAX_ROWS)) begin
            rows_eff = SIZE_W'(MAX_ROWS);
        end else begin
            rows_eff = num_rows_reg;
        end
        if (num_cols_reg == '0) begin
            cols_eff = SIZE_W'(1);
        end else if (num_cols_reg > SIZE_W'(MAX_COLS)) begin
            cols_eff = SIZE_W'(MAX_COLS);
        end else begin
            cols_eff = num_cols_reg;
        end
    end

    // hold input while a result could overflow the queue
    assign s_tready = ({1'b0, level} + (RES_CNT_W+1)'(ctl_reg.valid))
                      < (RES_CNT_W+1)'(RES_DEPTH);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= cols_eff;
        last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= rows_eff;

        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end

        ctl_next          = ctl_reg;
        ctl_next.valid    = s_accept;
        if (s_accept) begin
            ctl_next.free     = s_tdata[0];
            ctl_next.first    = (row_reg == '0) || (col_reg == '0);
            ctl_next.grid_end = last_col && last_row;
            ctl_next.row      = row_reg;
            ctl_next.col      = col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ctl_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            ctl_reg <= ctl_next;
        end
    end

    lfsq_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (top_score),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lfsq_score_unit u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_reg),
        .top_score (top_score),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_push  (res_push),
        .res       (res)
    );

    lfsq_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .level     (level)
    );

    assign m_tdata = {1'b0, out_res.left_col, out_res.top_row, out_res.square_side};

    `LFSQ_ASSERT_NEXT(a_accept_reaches_score, aclk, aresetn, s_accept, ctl_reg.valid)
    `LFSQ_ASSERT_NEXT(a_grid_end_wraps, aclk, aresetn, s_accept && last_col && last_row, (col_reg == '0) && (row_reg == '0))

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Largest free square finder testbench
// Streams grids of free and obstacle cells into the block and predicts, cell
// by cell, the first largest free square of every grid. Each result on the
// m_ side is compared field by field with the oldest prediction. Covers
// directed grids, zero grid sizes, a stretch without idling, a long receiver
// hold-off and random small grids with and without random idling on both sides.
// ----------------------------------------------------------------------------

module testbench;
    import lfsq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_CELLS = 420;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_addr;
    logic [SIZE_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [0] cell_free
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [10:0] square_side, [20:11] top_row, [30:21] left_col

    bit          steady;
    int unsigned hold_requests;
    int unsigned cycle_count;

    function automatic int unsigned grid_dim(logic [SIZE_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    class square_scoreboard;
        logic [SIZE_W-1:0]  rows_reg;
        logic [SIZE_W-1:0]  cols_reg;
        logic [SCORE_W-1:0] line_scores [MAX_COLS];
        logic [SCORE_W-1:0] left_sc;
        logic [SCORE_W-1:0] diag_sc;
        logic [SCORE_W-1:0] best_side;
        logic [ROW_W-1:0]   row_pos;
        logic [ROW_W-1:0]   best_row;
        logic [COL_W-1:0]   col_pos;
        logic [COL_W-1:0]   best_col;
        result_t            expected_squares [$];
        int unsigned        mismatches;

        function new();
            rows_reg = SIZE_W'(1);
            cols_reg = SIZE_W'(1);
            foreach (line_scores[k]) line_scores[k] = '0;
            mismatches = 0;
            restart_grid();
        endfunction

        function void restart_grid();
            left_sc = '0;
            diag_sc = '0;
            row_pos = '0;
            col_pos = '0;
            best_side = '0;
            best_row = '0;
            best_col = '0;
        endfunction

        function void set_size(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
            case (idx)
                REG_NUM_ROWS: rows_reg = val;
                REG_NUM_COLS: cols_reg = val;
                default: ;
            endcase
        endfunction

        function void log_error(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void note_cell(bit free);
            int unsigned rows, cols, i, j, top, score, low;
            result_t     res;
            rows = grid_dim(rows_reg, MAX_ROWS);
            cols = grid_dim(cols_reg, MAX_COLS);
            i = row_pos;
            j = col_pos;
            top = line_scores[j];
            if (!free) begin
                score = 0;
            end else if (i == 0 || j == 0) begin
                score = 1;
            end else begin
                low = (top < left_sc) ? top : left_sc;
                low = (low < diag_sc) ? low : diag_sc;
                score = (low + 1) & 32'h7FF;
            end
            diag_sc = SCORE_W'(top);
            left_sc = SCORE_W'(score);
            line_scores[j] = SCORE_W'(score);
            if (score > best_side) begin
                best_side = SCORE_W'(score);
                best_row = (score > i + 1) ? '0 : ROW_W'(i + 1 - score);
                best_col = (score > j + 1) ? '0 : COL_W'(j + 1 - score);
            end
            if (j + 1 >= cols) begin
                col_pos = '0;
                if (i + 1 >= rows) begin
                    res.square_side = best_side;
                    res.top_row = best_row;
                    res.left_col = best_col;
                    expected_squares.push_back(res);
                    restart_grid();
                end else begin
                    row_pos = ROW_W'(i + 1);
                end
            end else begin
                col_pos = COL_W'(j + 1);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t got, want;
            got = data[$bits(result_t)-1:0];
            if (expected_squares.size() == 0) begin
                log_error($sformatf("result error at %0t: unrequested side %0d row %0d col %0d",
                                    $time, got.square_side, got.top_row, got.left_col));
                return;
            end
            want = expected_squares.pop_front();
            if (got.square_side !== want.square_side || got.top_row !== want.top_row ||
                got.left_col !== want.left_col)
                log_error($sformatf({"result error at %0t: side %0d row %0d col %0d, ",
                                     "wanted side %0d row %0d col %0d"}, $time,
                                    got.square_side, got.top_row, got.left_col,
                                    want.square_side, want.top_row, want.left_col));
        endfunction
    endclass

    square_scoreboard sb;

    largest_free_square_finder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // hold the result side off on request, otherwise idle at random unless steady is set
    initial begin
        int unsigned hold_left, holds_done;
        hold_left = 0;
        holds_done = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_cell(input bit free);
        if (!steady) begin
            while ($urandom_range(99) < 18) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(free);
        do @(posedge aclk); while (!s_tready);
        sb.note_cell(free);
        @(negedge aclk);
    endtask

    task automatic send_grid(input int unsigned cells, input int unsigned free_pct);
        for (int unsigned k = 0; k < cells; k++) send_cell($urandom_range(99) < free_pct);
    endtask

    // obstacles up to the threshold, free cells from there on
    task automatic send_tail(input int unsigned cells, input int unsigned thr);
        for (int unsigned k = 0; k < cells; k++) send_cell(k >= thr);
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
        cfg_we <= 1'b1;
        cfg_addr <= REG_NUM_ROWS;
        cfg_wdata <= rows;
        @(negedge aclk);
        cfg_addr <= REG_NUM_COLS;
        cfg_wdata <= cols;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_size(REG_NUM_ROWS, rows);
        sb.set_size(REG_NUM_COLS, cols);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_squares.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [SIZE_W-1:0] random_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 80) return SIZE_W'($urandom_range(1, 6));
        return SIZE_W'($urandom_range(7, 16));
    endfunction

    initial begin
        int unsigned random_cells, phase, grids, pct, cells;
        logic [SIZE_W-1:0] rows_v, cols_v;
        sb = new();
        steady = 1'b0;
        hold_requests = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_NUM_ROWS;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sizes after reset give one-cell grids
        send_cell(1'b1);
        send_cell(1'b0);
        wait_idle();

        // zero sizes act as one
        write_sizes('0, '0);
        send_cell(1'b1);
        send_cell(1'b0);
        wait_idle();

        write_sizes(SIZE_W'(3), SIZE_W'(3));
        send_tail(9, 0);
        wait_idle();

        // two equal squares: keep the first in scan order
        write_sizes(SIZE_W'(2), SIZE_W'(5));
        for (int unsigned k = 0; k < 10; k++) send_cell((k % 5) != 2);
        wait_idle();

        // no idling on either side
        steady = 1'b1;
        write_sizes(SIZE_W'(8), SIZE_W'(8));
        send_grid(64, 90);
        wait_idle();
        steady = 1'b0;

        // fill the result queue while the receiver holds off
        write_sizes(SIZE_W'(1), SIZE_W'(1));
        hold_requests++;
        send_grid(40, 60);
        wait_idle();

        random_cells = 0;
        phase = 0;
        while (random_cells < RANDOM_CELLS) begin
            rows_v = random_dim();
            cols_v = random_dim();
            write_sizes(rows_v, cols_v);
            cells = grid_dim(rows_v, MAX_ROWS) * grid_dim(cols_v, MAX_COLS);
            grids = (cells > 64) ? 1 : $urandom_range(1, 4);
            pct = $urandom_range(40, 100);
            steady = (phase >= 4 && phase < 8);
            for (int unsigned g = 0; g < grids; g++) send_grid(cells, pct);
            random_cells += grids * cells;
            wait_idle();
            phase++;
        end
        steady = 1'b0;
        wait_idle();

        if (sb.mismatches == 0 && sb.expected_squares.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/lfsq_pkg.sv
design/lfsq_line_buf.sv
design/lfsq_score_unit.sv
design/lfsq_result_fifo.sv
design/largest_free_square_finder.sv
dv/testbench.sv
